[src/stop_velocity_profile_assert.svh]
// Assertion macros used by the asserting top-level file.
`ifndef STOP_VELOCITY_PROFILE_ASSERT_SVH
`define STOP_VELOCITY_PROFILE_ASSERT_SVH
`ifndef SYNTH
`define SVP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svp assertion failed");
`define SVP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svp assertion failed");
`else
`define SVP_ASSERT_SAME(label, ante, cons)
`define SVP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[src/svp_pkg.sv]
package svp_pkg;

    localparam int COORD_W     = 32;
    localparam int SPEED_W     = 16;
    localparam int INDEX_W     = 6;
    localparam int MAG_W       = 31;
    localparam int SQR_W       = 62;
    localparam int RAD_W       = 64;
    localparam int ROOT_W      = 32;
    localparam int REM_W       = ROOT_W + 2;
    localparam int SQRT_CNT_W  = 6;
    localparam int SCALE_SHIFT = 6;
    localparam int PROD_W      = SPEED_W + ROOT_W;
    localparam int SCALED_W    = PROD_W - SCALE_SHIFT;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DECEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THR  = 1'b1;

    localparam logic [SPEED_W-1:0] MAX_DECEL_RST = 16'd256;
    localparam logic [SPEED_W-1:0] STOP_THR_RST  = 16'd256;
    localparam logic [SPEED_W-1:0] SPEED_MAX     = 16'hFFFF;

    localparam logic [1:0] SUM_FIRST = 2'd0;
    localparam logic [1:0] SUM_LAST  = 2'd3;

    localparam logic ROOT_SEL_DIST  = 1'b0;
    localparam logic ROOT_SEL_SPEED = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_SUM,
        ST_ROOT1_GO,
        ST_ROOT1_WAIT,
        ST_SCALE,
        ST_ROOT2_GO,
        ST_ROOT2_WAIT,
        ST_EMIT
    } svp_state_t;

    typedef struct packed {
        logic       accept;
        logic       fetch;
        logic       load;
        logic       sq_mul;
        logic       sq_acc;
        logic [1:0] sq_sel;
        logic       root_start;
        logic       root_sel;
        logic       scale;
        logic       emit;
    } svp_cmd_t;

    typedef struct packed {
        logic last_index;
        logic root_done;
    } svp_sts_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [SPEED_W-1:0] speed;
    } svp_entry_t;

    // |a - b| >> 1, differences taken at 33 bits
    function automatic logic [MAG_W-1:0] half_mag(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        begin
            d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
            m = d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
            return m[MAG_W:1];
        end
    endfunction

endpackage

[src/svp_sqrt.sv]
module svp_sqrt
    import svp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;

    always_comb
    begin
        rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            cnt_next  = SQRT_CNT_W'(ROOT_W);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - SQRT_CNT_W'(1);
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = (cnt_reg == SQRT_CNT_W'(1));
    assign root = root_reg;

endmodule

[src/svp_dp.sv]
module svp_dp
    import svp_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  svp_cmd_t             cmd,
    output svp_sts_t             sts,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SPEED_W-1:0]   cfg_data,
    input  logic [COORD_W-1:0]   x_pos,
    input  logic [COORD_W-1:0]   y_pos,
    input  logic [COORD_W-1:0]   z_pos,
    input  logic [SPEED_W-1:0]   speed_limit,
    input  logic                 last_point,
    output logic                 result_valid,
    output logic [INDEX_W-1:0]   point_index,
    output logic [SPEED_W-1:0]   limited_speed,
    output logic                 final_result,
    output logic                 overflowed
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    svp_entry_t mem [MAX_POINTS];
    svp_entry_t rd_reg;

    logic [CNT_W-1:0]    count_reg;
    logic                drop_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                full;
    logic                last_index;

    logic [SPEED_W-1:0]  max_decel_reg;
    logic [SPEED_W-1:0]  stop_thr_reg;

    logic [COORD_W-1:0]  ref_x_reg, ref_y_reg, ref_z_reg;
    logic [MAG_W-1:0]    mag_x_reg, mag_y_reg, mag_z_reg;
    logic [MAG_W-1:0]    mag_sel;
    logic [SQR_W-1:0]    sq_reg;
    logic [RAD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled_reg;
    logic [RAD_W-1:0]    radicand;
    logic                root_done;
    logic [ROOT_W-1:0]   root;

    logic [SPEED_W-1:0]  v_sat, v_thr, v_lim;

    logic                result_valid_reg;
    logic [INDEX_W-1:0]  point_index_reg;
    logic [SPEED_W-1:0]  limited_speed_reg;
    logic                final_result_reg;
    logic                overflowed_reg;

    assign full       = (count_reg == CNT_W'(MAX_POINTS));
    assign last_index = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // store
    always_ff @(posedge clk)
    begin
        if (cmd.accept && !full)
        begin
            mem[count_reg[IDX_W-1:0]] <= '{x: x_pos, y: y_pos, z: z_pos, speed: speed_limit};
        end
        if (cmd.fetch)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            idx_reg       <= '0;
            max_decel_reg <= MAX_DECEL_RST;
            stop_thr_reg  <= STOP_THR_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAX_DECEL)
                begin
                    max_decel_reg <= cfg_data;
                end
                else if (cfg_index == CFG_STOP_THR)
                begin
                    stop_thr_reg <= cfg_data;
                end
            end
            if (cmd.accept)
            begin
                if (full)
                begin
                    drop_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (last_point)
                begin
                    idx_reg <= '0;
                end
            end
            if (cmd.emit)
            begin
                if (last_index)
                begin
                    count_reg <= '0;
                    drop_reg  <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // distance and speed arithmetic
    always_comb
    begin
        unique case (cmd.sq_sel)
            2'd0:    mag_sel = mag_x_reg;
            2'd1:    mag_sel = mag_y_reg;
            2'd2:    mag_sel = mag_z_reg;
            default: mag_sel = '0;
        endcase
    end

    assign prod     = max_decel_reg * root;
    assign radicand = (cmd.root_sel == ROOT_SEL_SPEED) ? RAD_W'(scaled_reg) : acc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && last_point)
        begin
            ref_x_reg <= x_pos;
            ref_y_reg <= y_pos;
            ref_z_reg <= z_pos;
        end
        if (cmd.load)
        begin
            mag_x_reg <= half_mag(rd_reg.x, ref_x_reg);
            mag_y_reg <= half_mag(rd_reg.y, ref_y_reg);
            mag_z_reg <= half_mag(rd_reg.z, ref_z_reg);
            acc_reg   <= '0;
        end
        if (cmd.sq_mul)
        begin
            sq_reg <= mag_sel * mag_sel;
        end
        if (cmd.sq_acc)
        begin
            acc_reg <= acc_reg + RAD_W'(sq_reg);
        end
        if (cmd.scale)
        begin
            scaled_reg <= prod[PROD_W-1:SCALE_SHIFT];
        end
    end

    svp_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    always_comb
    begin
        v_sat = (root[ROOT_W-1:SPEED_W] != '0) ? SPEED_MAX : root[SPEED_W-1:0];
        v_thr = (v_sat < stop_thr_reg) ? '0 : v_sat;
        v_lim = (v_thr > rd_reg.speed) ? rd_reg.speed : v_thr;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            point_index_reg   <= INDEX_W'(idx_reg);
            limited_speed_reg <= v_lim;
            final_result_reg  <= last_index;
            overflowed_reg    <= drop_reg;
        end
    end

    assign sts.last_index = last_index;
    assign sts.root_done  = root_done;

    assign result_valid  = result_valid_reg;
    assign point_index   = point_index_reg;
    assign limited_speed = limited_speed_reg;
    assign final_result  = final_result_reg;
    assign overflowed    = overflowed_reg;

endmodule

[src/svp_ctrl.sv]
module svp_ctrl
    import svp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     last_point,
    input  svp_sts_t sts,
    output svp_cmd_t cmd,
    output logic     busy
);

    svp_state_t state_reg, state_next;
    logic [1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= SUM_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = start;
                if (start && last_point)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = SUM_FIRST;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // square one axis per cycle, add the previous square
                cmd.sq_sel = step_reg;
                cmd.sq_mul = (step_reg != SUM_LAST);
                cmd.sq_acc = (step_reg != SUM_FIRST);
                step_next  = step_reg + 2'd1;
                if (step_reg == SUM_LAST)
                begin
                    state_next = ST_ROOT1_GO;
                end
            end
            ST_ROOT1_GO:
            begin
                cmd.root_start = 1'b1;
                cmd.root_sel   = ROOT_SEL_DIST;
                state_next     = ST_ROOT1_WAIT;
            end
            ST_ROOT1_WAIT:
            begin
                if (sts.root_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_ROOT2_GO;
            end
            ST_ROOT2_GO:
            begin
                cmd.root_start = 1'b1;
                cmd.root_sel   = ROOT_SEL_SPEED;
                state_next     = ST_ROOT2_WAIT;
            end
            ST_ROOT2_WAIT:
            begin
                cmd.root_sel = ROOT_SEL_SPEED;
                if (sts.root_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = sts.last_index ? ST_IDLE : ST_FETCH;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/stop_velocity_profile.sv]
// Waypoints are written one item per cycle with start while busy is low; each
// non-final item leaves busy low. The item with last_point set is the stop
// point: it raises busy and starts a run that gives one result per stored
// point, in store order, and busy falls with the last result. Each point runs
// the bit-serial square root unit twice (distance, then speed), 32 steps each
// time. Each result is shown for one cycle with result_valid and cannot be
// held off: capture it in that cycle. Up to MAX_POINTS points are stored;
// later ones are dropped and flagged on overflowed.
`include "stop_velocity_profile_assert.svh"

module stop_velocity_profile
    import svp_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [COORD_W-1:0]   x_pos,
    input  logic signed [COORD_W-1:0]   y_pos,
    input  logic signed [COORD_W-1:0]   z_pos,
    input  logic        [SPEED_W-1:0]   speed_limit,
    input  logic                        last_point,
    output logic                        result_valid,
    output logic        [INDEX_W-1:0]   point_index,
    output logic        [SPEED_W-1:0]   limited_speed,
    output logic                        final_result,
    output logic                        overflowed,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic        [CFG_IDX_W-1:0] cfg_index,
    input  logic        [SPEED_W-1:0]   cfg_data
);

    svp_cmd_t cmd;
    svp_sts_t sts;

    assign cfg_ready = 1'b1;

    svp_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_point (last_point),
        .sts        (sts),
        .cmd        (cmd),
        .busy       (busy)
    );

    svp_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .z_pos         (z_pos),
        .speed_limit   (speed_limit),
        .last_point    (last_point),
        .result_valid  (result_valid),
        .point_index   (point_index),
        .limited_speed (limited_speed),
        .final_result  (final_result),
        .overflowed    (overflowed)
    );

    `SVP_ASSERT_SAME(a_mid_run_busy, result_valid && !final_result, busy)
    `SVP_ASSERT_NEXT(a_idle_no_result, start && !busy, !result_valid)
    `SVP_ASSERT_SAME(a_run_from_stop, $rose(busy), $past(start && last_point))

endmodule

[dv/stop_velocity_profile_test.sv]
module stop_velocity_profile_test
    import svp_pkg::*;
();

    localparam int DEPTH      = 64;
    localparam int GAP_MAX    = 12;
    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL       = 200;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] ONE_M     = 32'sd65536;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic        [SPEED_W-1:0] speed;
    } waypoint_t;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [SPEED_W-1:0] speed;
        logic               final_flag;
        logic               drop;
    } profile_t;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        start         = 1'b0;
    logic                        busy;
    logic signed [COORD_W-1:0]   x_pos         = '0;
    logic signed [COORD_W-1:0]   y_pos         = '0;
    logic signed [COORD_W-1:0]   z_pos         = '0;
    logic        [SPEED_W-1:0]   speed_limit   = '0;
    logic                        last_point    = 1'b0;
    logic                        result_valid;
    logic        [INDEX_W-1:0]   point_index;
    logic        [SPEED_W-1:0]   limited_speed;
    logic                        final_result;
    logic                        overflowed;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic        [CFG_IDX_W-1:0] cfg_index     = CFG_MAX_DECEL;
    logic        [SPEED_W-1:0]   cfg_data      = '0;

    waypoint_t          path[$];
    logic               dropped_any  = 1'b0;
    logic [SPEED_W-1:0] decel_q88    = MAX_DECEL_RST;
    logic [SPEED_W-1:0] floor_q88    = STOP_THR_RST;
    profile_t           profile_q[$];
    int                 err_count    = 0;
    int                 idle_cycles  = 0;
    int                 random_items = 0;
    bit                 quiet        = 1'b0;

    stop_velocity_profile #(
        .MAX_POINTS (DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .z_pos         (z_pos),
        .speed_limit   (speed_limit),
        .last_point    (last_point),
        .result_valid  (result_valid),
        .point_index   (point_index),
        .limited_speed (limited_speed),
        .final_result  (final_result),
        .overflowed    (overflowed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        root = '0;
        for (b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    // |a - b| / 2 in units of 2^-15 m
    function automatic logic [63:0] half_gap(input logic signed [COORD_W-1:0] a,
                                             input logic signed [COORD_W-1:0] b);
        longint diff;
        diff = longint'(a) - longint'(b);
        if (diff < 0)
            diff = -diff;
        return 64'(diff) >> 1;
    endfunction

    function automatic logic [SPEED_W-1:0] stop_speed(input waypoint_t p, input waypoint_t stop);
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] dz;
        logic [63:0] span;
        logic [63:0] v;
        dx   = half_gap(p.x, stop.x);
        dy   = half_gap(p.y, stop.y);
        dz   = half_gap(p.z, stop.z);
        span = floor_sqrt(dx * dx + dy * dy + dz * dz);
        v    = floor_sqrt((64'(decel_q88) * span) >> SCALE_SHIFT);
        if (v > 64'(SPEED_MAX))
            v = 64'(SPEED_MAX);
        if (v < 64'(floor_q88))
            v = '0;
        if (v > 64'(p.speed))
            v = 64'(p.speed);
        return v[SPEED_W-1:0];
    endfunction

    task automatic take_waypoint(input waypoint_t w, input logic last);
        profile_t r;
        int       n;
        int       i;
        if (path.size() < DEPTH)
            path = {path, w};
        else
            dropped_any = 1'b1;
        if (last)
        begin
            n = path.size();
            for (i = 0; i < n; i++)
            begin
                r.index      = INDEX_W'(i);
                r.speed      = stop_speed(path[i], w);
                r.final_flag = (i == n - 1);
                r.drop       = dropped_any;
                profile_q    = {profile_q, r};
            end
            path.delete();
            dropped_any = 1'b0;
        end
    endtask

    task automatic send_waypoint(input logic signed [COORD_W-1:0] x,
                                 input logic signed [COORD_W-1:0] y,
                                 input logic signed [COORD_W-1:0] z,
                                 input logic [SPEED_W-1:0] spd,
                                 input logic last);
        int        gap;
        waypoint_t w;
        gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        x_pos       <= x;
        y_pos       <= y;
        z_pos       <= z;
        speed_limit <= spd;
        last_point  <= last;
        do @(posedge clk); while (busy);
        w.x     = x;
        w.y     = y;
        w.z     = z;
        w.speed = spd;
        take_waypoint(w, last);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (profile_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limits(input logic [SPEED_W-1:0] decel, input logic [SPEED_W-1:0] thr);
        drain_results();
        while (busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAX_DECEL;
        cfg_data  <= decel;
        do @(posedge clk); while (!cfg_ready);
        decel_q88 = decel;
        cfg_index <= CFG_STOP_THR;
        cfg_data  <= thr;
        do @(posedge clk); while (!cfg_ready);
        floor_q88 = thr;
        cfg_valid <= 1'b0;
    endtask

    // offset with a random magnitude from sub-unit to full range
    function automatic logic signed [COORD_W-1:0] spread();
        logic [COORD_W-1:0] m;
        m = $urandom() >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [SPEED_W-1:0] rand_speed();
        case ($urandom_range(0, 2))
            0:       return SPEED_W'($urandom());
            1:       return SPEED_W'($urandom_range(0, 2047));
            default: return SPEED_MAX;
        endcase
    endfunction

    function automatic logic [SPEED_W-1:0] rand_reg();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return SPEED_MAX;
            2:       return SPEED_W'($urandom_range(0, 1023));
            default: return SPEED_W'($urandom());
        endcase
    endfunction

    function automatic waypoint_t random_point();
        waypoint_t w;
        w.x     = $urandom();
        w.y     = $urandom();
        w.z     = $urandom();
        w.speed = rand_speed();
        return w;
    endfunction

    task automatic send_near(input waypoint_t stop, input logic last, input bit wild);
        waypoint_t w;
        if (last)
            send_waypoint(stop.x, stop.y, stop.z, stop.speed, 1'b1);
        else if (wild)
        begin
            w = random_point();
            send_waypoint(w.x, w.y, w.z, w.speed, 1'b0);
        end
        else
            send_waypoint(stop.x + spread(), stop.y + spread(), stop.z + spread(),
                          rand_speed(), 1'b0);
    endtask

    task automatic test_lone_stop_point();
        send_waypoint('0, '0, '0, SPEED_MAX, 1'b1);
    endtask

    task automatic test_range_extremes();
        send_waypoint(COORD_MAX, COORD_MAX, COORD_MAX, SPEED_MAX, 1'b0);
        send_waypoint(COORD_MIN, COORD_MIN, COORD_MIN, SPEED_MAX, 1'b0);
        send_waypoint('0, '0, '0, '0, 1'b0);
        send_waypoint(COORD_MIN + 1, COORD_MIN, COORD_MIN, SPEED_MAX, 1'b0);
        send_waypoint(COORD_MAX, '0, '0, 16'h0123, 1'b0);
        send_waypoint(COORD_MIN, COORD_MIN, COORD_MIN, 16'h8000, 1'b1);
    endtask

    task automatic test_decel_extremes();
        set_limits(SPEED_MAX, '0);
        send_waypoint(COORD_MAX, COORD_MIN, COORD_MAX, SPEED_MAX, 1'b0);
        send_waypoint(ONE_M, '0, '0, SPEED_MAX, 1'b0);
        send_waypoint('0, '0, '0, SPEED_MAX, 1'b0);
        send_waypoint('0, '0, '0, SPEED_MAX, 1'b1);
        set_limits('0, '0);
        send_waypoint(COORD_MAX, COORD_MAX, COORD_MIN, SPEED_MAX, 1'b0);
        send_waypoint(32'sd1, 32'sd2, 32'sd3, SPEED_MAX, 1'b1);
        set_limits(MAX_DECEL_RST, SPEED_MAX);
        send_waypoint(COORD_MAX, COORD_MAX, COORD_MAX, SPEED_MAX, 1'b0);
        send_waypoint(ONE_M * 10, '0, '0, SPEED_MAX, 1'b0);
        send_waypoint(COORD_MIN, COORD_MIN, COORD_MIN, SPEED_MAX, 1'b1);
    endtask

    // 1 m at 1.0 m/s^2 gives v = 362 (1.414 m/s)
    task automatic test_threshold_edge();
        set_limits(MAX_DECEL_RST, 16'd362);
        send_waypoint(ONE_M, '0, '0, SPEED_MAX, 1'b0);
        send_waypoint('0, '0, '0, SPEED_MAX, 1'b1);
        set_limits(MAX_DECEL_RST, 16'd363);
        send_waypoint(ONE_M, '0, '0, SPEED_MAX, 1'b0);
        send_waypoint('0, '0, '0, SPEED_MAX, 1'b1);
        set_limits(MAX_DECEL_RST, STOP_THR_RST);
    endtask

    task automatic test_store_overflow();
        waypoint_t stop;
        int        k;
        stop = random_point();
        for (k = 0; k < DEPTH; k++)
            send_near(stop, k == DEPTH - 1, 1'b0);
        // two past capacity, stop point dropped too
        stop = random_point();
        for (k = 0; k < DEPTH + 2; k++)
            send_near(stop, k == DEPTH + 1, 1'b0);
    endtask

    task automatic test_random_paths();
        waypoint_t stop;
        int        npts;
        int        runs;
        int        k;
        bit        wild;
        runs = 0;
        while (random_items < 260)
        begin
            if (runs % 6 == 5)
                set_limits(rand_reg(), rand_reg());
            quiet = ($urandom_range(0, 3) == 0);
            wild  = ($urandom_range(0, 4) == 0);
            npts  = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            stop  = random_point();
            for (k = 0; k < npts; k++)
                send_near(stop, k == npts - 1, wild);
            random_items += npts;
            if ($urandom_range(0, 4) == 0)
                drain_results();
            runs++;
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin
        profile_t want;
        if (rst_n && result_valid)
        begin
            if (profile_q.size() == 0)
            begin
                $error("unexpected result: point_index %0d limited_speed %0d",
                       point_index, limited_speed);
                err_count++;
            end
            else
            begin
                want = profile_q.pop_front();
                if (point_index !== want.index)
                begin
                    $error("point_index expected %0d actual %0d", want.index, point_index);
                    err_count++;
                end
                if (limited_speed !== want.speed)
                begin
                    $error("limited_speed expected %0d actual %0d", want.speed, limited_speed);
                    err_count++;
                end
                if (final_result !== want.final_flag)
                begin
                    $error("final_result expected %0b actual %0b", want.final_flag, final_result);
                    err_count++;
                end
                if (overflowed !== want.drop)
                begin
                    $error("overflowed expected %0b actual %0b", want.drop, overflowed);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_lone_stop_point();
        test_range_extremes();
        test_decel_extremes();
        test_threshold_edge();
        test_store_overflow();
        test_random_paths();
        drain_results();
        repeat (TAIL) @(posedge clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
